// ===== rtl/group_reverse_stream_top_defines.svh =====
// Assertion macros for the group reverse stream block.
// Included by the top level; expects signals clk and arst_n in scope.
`ifndef GROUP_REVERSE_STREAM_TOP_DEFINES_SVH
`define GROUP_REVERSE_STREAM_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Property must hold on every rising clock edge outside reset.
`define GRS_ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define GRS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define GRS_ASSERT_ALWAYS(label, expr, msg)
`define GRS_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== rtl/grs_pkg.sv =====
// Shared constants and types for the group reverse stream block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package grs_pkg;
	localparam int MAX_GROUP  = 16;
	localparam int DATA_WIDTH = 32;
	localparam int CNT_W      = $clog2(MAX_GROUP + 1);
	localparam int TDATA_W    = ((DATA_WIDTH + 7) / 8) * 8;
	localparam int CFG_W      = 5;

	typedef logic [DATA_WIDTH-1:0] data_t;
	typedef logic [CNT_W-1:0]      cnt_t;

	// Shift commands broadcast from the controller to the row of cells.
	typedef struct packed {
		logic shift_up;
		logic shift_down;
		logic sel_top;
	} grs_ctrl_t;
endpackage

// ===== rtl/group_reverse_stream_top.sv =====
// Top level of the group reverse stream block: a row of value cells and
// its sequencer. Depends on grs_pkg, grs_cell, grs_ctrl and the defines header.
`timescale 1ns / 1ps
// How to use this block:
// Values arrive as requests on the slave stream (s_tdata, s_tlast marks the
// final value of a sequence). Results leave on the master stream in the same
// format. The single register, the group size, is written through cfg_we and
// cfg_wdata; the user must write it only while the block is idle, which the
// block itself does not enforce. Sizes 0 and 1 pass values through, and sizes
// above 16 act as 16. Each accepted value is pushed into a row of 16 cells that
// shift by one position per cycle unless the receiver stalls. When a group is
// complete, the block stops taking requests and pops the row from its low end,
// newest value first, one result per cycle while the receiver is ready.
// A short trailing group on the last value is first slid to the high end of
// the row and then shifted out oldest first. For a full group, the first
// result appears in the cycle after the request that completes it. The shift
// row sets the rate: one cell move per cycle in either direction.
// When the receiver stalls, the row holds and the current result stays on
// m_tdata. s_tready is low while any result of a group is outstanding.
// Reset clears the fill count and the sequencer and sets the size to 1; the
// cell contents are left undefined and are never read before being written.
module group_reverse_stream_top
	import grs_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [CFG_W-1:0]   cfg_wdata,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [TDATA_W-1:0] s_tdata,   // [31:0] value
	input  logic               s_tlast,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,   // [31:0] value_out
	output logic               m_tlast
);
`include "group_reverse_stream_top_defines.svh"

	grs_ctrl_t ctrl;
	data_t     cell_val [MAX_GROUP];

	grs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tlast   (s_tlast),
		.s_tready  (s_tready),
		.m_tvalid  (m_tvalid),
		.m_tlast   (m_tlast),
		.m_tready  (m_tready),
		.ctrl      (ctrl)
	);

	// Cell 0 takes new input on an upward shift; the top cell holds its own
	// value on a downward shift, which is never read afterward anyway.
	for (genvar i = 0; i < MAX_GROUP; i++) begin : g_cell
		data_t lo_in;
		data_t hi_in;
		if (i == 0) begin : g_first
			assign lo_in = s_tdata[DATA_WIDTH-1:0];
		end else begin : g_mid_lo
			assign lo_in = cell_val[i-1];
		end
		if (i == MAX_GROUP - 1) begin : g_last
			assign hi_in = cell_val[i];
		end else begin : g_mid_hi
			assign hi_in = cell_val[i+1];
		end
		grs_cell u_cell (
			.clk     (clk),
			.ctrl    (ctrl),
			.from_lo (lo_in),
			.from_hi (hi_in),
			.value   (cell_val[i])
		);
	end

	// Reversed groups leave from the low end, in-order tails from the high end.
	assign m_tdata = TDATA_W'(ctrl.sel_top ? cell_val[MAX_GROUP-1] : cell_val[0]);

	`GRS_ASSERT_ALWAYS(a_no_overlap, !(s_tready && m_tvalid), "input taken while draining")
	`GRS_ASSERT_ALWAYS(a_last_valid, !m_tlast || m_tvalid, "last mark without a result")
	`GRS_ASSERT_NEXT(a_end_idle, m_tvalid && m_tready && m_tlast, !m_tvalid, "result after end")
	`GRS_ASSERT_NEXT(a_last_drains, s_tvalid && s_tready && s_tlast, !s_tready, "last not flushed")
endmodule

// ===== rtl/grs_cell.sv =====
// One storage cell of the shift row: holds a single value.
// Depends on grs_pkg for the data type and the command struct.
`timescale 1ns / 1ps
module grs_cell
	import grs_pkg::*;
(
	input  logic      clk,
	input  grs_ctrl_t ctrl,
	input  data_t     from_lo,
	input  data_t     from_hi,
	output data_t     value
);
	data_t value_q;

	// Payload only, so no reset.
	always_ff @(posedge clk) begin
		if (ctrl.shift_up) begin
			value_q <= from_lo;
		end else if (ctrl.shift_down) begin
			value_q <= from_hi;
		end
	end

	assign value = value_q;
endmodule

// ===== rtl/grs_ctrl.sv =====
// Sequencer for the group reverse stream: fill count, group size register
// and the drain state machine. Depends on grs_pkg.
`timescale 1ns / 1ps
module grs_ctrl
	import grs_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	input  logic             s_tvalid,
	input  logic             s_tlast,
	output logic             s_tready,
	output logic             m_tvalid,
	output logic             m_tlast,
	input  logic             m_tready,
	output grs_ctrl_t        ctrl
);
	typedef enum logic [1:0] {ST_IDLE, ST_ALIGN, ST_REV, ST_FWD} state_t;

	state_t           state_q;
	logic [CFG_W-1:0] gsize_q;
	cnt_t             fill_q;
	cnt_t             rem_q;
	cnt_t             align_q;
	logic             last_q;
	cnt_t             k_eff;
	cnt_t             n_next;
	logic             in_acc;
	logic             out_acc;

	always_comb begin
		if (gsize_q <= CFG_W'(1)) begin
			k_eff = cnt_t'(1);
		end else if (gsize_q > CFG_W'(MAX_GROUP)) begin
			k_eff = cnt_t'(MAX_GROUP);
		end else begin
			k_eff = cnt_t'(gsize_q);
		end
	end

	assign n_next   = fill_q + cnt_t'(1);
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_REV) || (state_q == ST_FWD);
	assign m_tlast  = m_tvalid && last_q && (rem_q == cnt_t'(1));
	assign in_acc   = s_tvalid && s_tready;
	assign out_acc  = m_tvalid && m_tready;

	always_comb begin
		ctrl.shift_up   = 1'b0;
		ctrl.shift_down = 1'b0;
		ctrl.sel_top    = 1'b0;
		case (state_q)
			ST_IDLE:  ctrl.shift_up = in_acc;
			ST_ALIGN: ctrl.shift_up = 1'b1;
			ST_REV:   ctrl.shift_down = m_tready;
			ST_FWD: begin
				ctrl.shift_up = m_tready;
				ctrl.sel_top  = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			gsize_q <= CFG_W'(1);
			fill_q  <= '0;
			rem_q   <= '0;
			align_q <= '0;
			last_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				gsize_q <= cfg_wdata;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (n_next >= k_eff) begin
							state_q <= ST_REV;
							rem_q   <= n_next;
							last_q  <= s_tlast;
							fill_q  <= '0;
						end else if (s_tlast) begin
							// Short tail: slide it to the top end, then send oldest first.
							state_q <= ST_ALIGN;
							rem_q   <= n_next;
							align_q <= cnt_t'(MAX_GROUP) - n_next;
							last_q  <= 1'b1;
							fill_q  <= '0;
						end else begin
							fill_q <= n_next;
						end
					end
				end
				ST_ALIGN: begin
					if (align_q == cnt_t'(1)) begin
						state_q <= ST_FWD;
					end
					align_q <= align_q - cnt_t'(1);
				end
				ST_REV, ST_FWD: begin
					if (out_acc) begin
						if (rem_q == cnt_t'(1)) begin
							state_q <= ST_IDLE;
						end
						rem_q <= rem_q - cnt_t'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== dv/tb_group_reverse_stream_top.sv =====
// Self-checking testbench for group_reverse_stream_top: directed table, then random
// sequences under several group sizes, with random bursts on both streams.
// Depends on grs_pkg and the RTL of the block; nothing else.
`timescale 1ns / 1ps
module tb_group_reverse_stream_top;
	import grs_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int RANDOM_ITEMS  = 260;
	localparam int HOLD_CYCLES   = 300;
	// A short trailing group slides to the high end of the row before it leaves.
	localparam int IDLE_SETTLE   = 2 * MAX_GROUP + 8;
	localparam int DRAIN_CYCLES  = 60;
	localparam int DIR_ROWS      = 30;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

	// One step of the directed table. For ROW_CFG the value holds the new size.
	typedef struct packed {
		row_kind_e kind;
		data_t     value;
		logic      mark_last;
		logic      typed;
		data_t     exp_value;
		logic      exp_last;
	} dir_row_t;

	typedef struct packed {
		data_t value;
		logic  is_last;
	} reordered_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_we;
	logic [CFG_W-1:0]   cfg_wdata;
	logic               s_tvalid;
	logic               s_tready;
	logic [TDATA_W-1:0] s_tdata;   // [31:0] value
	logic               s_tlast;
	logic               m_tvalid;
	logic               m_tready;
	logic [TDATA_W-1:0] m_tdata;   // [31:0] value_out
	logic               m_tlast;

	group_reverse_stream_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	// Predictor state: the group size register and the values held so far.
	logic [CFG_W-1:0] size_reg;
	data_t            held_values [MAX_GROUP];
	int               held_count;

	reordered_t reordered_q [$];

	int  mismatches;
	int  items_sent;
	int  results_seen;
	int  cfg_writes;
	int  cycles;
	int  burst_left;
	bit  steady_send;
	bit  hold_request;

	dir_row_t dir_rows [DIR_ROWS] = '{
		// Reset size is 1: every request comes straight back.
		'{ROW_ITEM, 32'h7FFF_FFFF, 1'b0, 1'b1, 32'h7FFF_FFFF, 1'b0},
		'{ROW_ITEM, 32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000, 1'b1},
		'{ROW_ITEM, 32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000, 1'b0},
		'{ROW_ITEM, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1},
		// Size 0 behaves as pass-through too.
		'{ROW_CFG,  32'd0,         1'b0, 1'b0, 32'h0,         1'b0},
		'{ROW_ITEM, 32'h1234_5678, 1'b1, 1'b1, 32'h1234_5678, 1'b1},
		'{ROW_ITEM, 32'hA5A5_A5A5, 1'b0, 1'b1, 32'hA5A5_A5A5, 1'b0},
		// Full group of four, then a short trailing group of two.
		'{ROW_CFG,  32'd4,         1'b0, 1'b0, 32'h0,         1'b0},
		'{ROW_ITEM, 32'd1,         1'b0, 1'b0, 32'h0,         1'b0},
		'{ROW_ITEM, 32'd2,         1'b0, 1'b0, 32'h0,         1'b0},
		'{ROW_ITEM, 32'd3,         1'b0, 1'b0, 32'h0,         1'b0},
		'{ROW_ITEM, 32'd4,         1'b0, 1'b0, 32'h0,         1'b0},
		'{ROW_ITEM, 32'd5,         1'b0, 1'b0, 32'h0,         1'b0},
		'{ROW_ITEM, 32'd6,         1'b1, 1'b0, 32'h0,         1'b0},
		// A full group that ends on the last request.
		'{ROW_ITEM, 32'd7,         1'b0, 1'b0, 32'h0,         1'b0},
		'{ROW_ITEM, 32'd8,         1'b0, 1'b0, 32'h0,         1'b0},
		'{ROW_ITEM, 32'd9,         1'b0, 1'b0, 32'h0,         1'b0},
		'{ROW_ITEM, 32'd10,        1'b1, 1'b0, 32'h0,         1'b0},
		// Size above the row depth saturates; three values form a short group.
		'{ROW_CFG,  32'd20,        1'b0, 1'b0, 32'h0,         1'b0},
		'{ROW_ITEM, 32'h11,        1'b0, 1'b0, 32'h0,         1'b0},
		'{ROW_ITEM, 32'h22,        1'b0, 1'b0, 32'h0,         1'b0},
		'{ROW_ITEM, 32'h33,        1'b1, 1'b0, 32'h0,         1'b0},
		// Size lowered while three values are held: the next one flushes all four.
		'{ROW_CFG,  32'd8,         1'b0, 1'b0, 32'h0,         1'b0},
		'{ROW_ITEM, 32'h44,        1'b0, 1'b0, 32'h0,         1'b0},
		'{ROW_ITEM, 32'h55,        1'b0, 1'b0, 32'h0,         1'b0},
		'{ROW_ITEM, 32'h66,        1'b0, 1'b0, 32'h0,         1'b0},
		'{ROW_CFG,  32'd2,         1'b0, 1'b0, 32'h0,         1'b0},
		'{ROW_ITEM, 32'h77,        1'b0, 1'b0, 32'h0,         1'b0},
		'{ROW_ITEM, 32'h88,        1'b1, 1'b0, 32'h0,         1'b0},
		'{ROW_CFG,  32'd1,         1'b0, 1'b0, 32'h0,         1'b0}
	};

	always #5 clk = ~clk;

	function automatic int active_size(input logic [CFG_W-1:0] sz);
		if (sz <= 1)
			return 1;
		if (sz > MAX_GROUP)
			return MAX_GROUP;
		return sz;
	endfunction

	// Works out the results that one accepted request causes.
	function automatic void predict_reorder(input data_t v, input logic mark_last,
			output reordered_t outs [$]);
		int k;
		int n;
		k = active_size(size_reg);
		outs = {};
		if (held_count < MAX_GROUP) begin
			held_values[held_count] = v;
			held_count++;
		end
		n = held_count;
		if (n >= k) begin
			for (int i = 0; i < n; i++)
				outs.push_back('{held_values[n - 1 - i], 1'b0});
		end else if (mark_last) begin
			for (int i = 0; i < n; i++)
				outs.push_back('{held_values[i], 1'b0});
		end else begin
			return;
		end
		if (mark_last)
			outs[n - 1].is_last = 1'b1;
		held_count = 0;
	endfunction

	function automatic data_t pick_value();
		case ($urandom_range(0, 7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	task automatic wait_drained();
		while (reordered_q.size() != 0)
			@(posedge clk);
	endtask

	// Offers one request, with a random gap at the start of each burst.
	task automatic offer_item(input data_t v, input logic mark_last);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = steady_send ? 0 : $urandom_range(0, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= v;
		s_tlast  <= mark_last;
		do
			@(posedge clk);
		while (!s_tready);
		items_sent++;
	endtask

	task automatic send_and_predict(input data_t v, input logic mark_last);
		reordered_t fresh [$];
		offer_item(v, mark_last);
		predict_reorder(v, mark_last, fresh);
		foreach (fresh[i])
			reordered_q.push_back(fresh[i]);
	endtask

	// The size is written only once the block has nothing left to send.
	task automatic write_group_size(input logic [CFG_W-1:0] sz);
		s_tvalid <= 1'b0;
		wait_drained();
		repeat (IDLE_SETTLE) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= sz;
		@(posedge clk);
		cfg_we   <= 1'b0;
		size_reg = sz;
		cfg_writes++;
	endtask

	// Receiver: a long hold-off on request, otherwise a changing stall pattern.
	initial begin
		int hold_left;
		int mode;
		int mode_left;
		int tick;
		hold_left = 0;
		mode      = 0;
		mode_left = 0;
		tick      = 0;
		m_tready  = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = HOLD_CYCLES;
				m_tready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode      = $urandom_range(0, 3);
					mode_left = $urandom_range(20, 120);
				end
				mode_left--;
				tick++;
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= $urandom_range(0, 1);
					2: m_tready <= (tick % 5) != 0;
					default: m_tready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// Results are checked on the falling edge before the edge that accepts them, so the
	// expectations of the request accepted at that edge are never involved.
	always @(negedge clk) begin
		reordered_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (reordered_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: value %h last %b",
						m_tdata[DATA_WIDTH-1:0], m_tlast);
			end else begin
				want = reordered_q.pop_front();
				if (m_tdata[DATA_WIDTH-1:0] !== want.value || m_tlast !== want.is_last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: value exp %h got %h, last exp %b got %b",
							want.value, m_tdata[DATA_WIDTH-1:0], want.is_last, m_tlast);
				end
			end
		end
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles, %0d results outstanding",
			cycles, reordered_q.size());
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		logic [CFG_W-1:0] phase_sizes [12] = '{16, 31, 0, 2, 3, 1, 5, 8, 12, 15, 4, 7};
		logic [CFG_W-1:0] sz;
		reordered_t       fresh [$];
		dir_row_t         row;
		int               run_left;
		int               stage;
		int               stage_items;
		logic             mark_last;

		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = '0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tlast      = 1'b0;
		size_reg     = 1;
		held_count   = 0;
		mismatches   = 0;
		items_sent   = 0;
		results_seen = 0;
		cfg_writes   = 0;
		cycles       = 0;
		burst_left   = 0;
		steady_send  = 1'b0;
		hold_request = 1'b0;
		run_left     = 0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table; rows with a typed result override the prediction.
		for (int r = 0; r < DIR_ROWS; r++) begin
			row = dir_rows[r];
			if (row.kind == ROW_CFG) begin
				write_group_size(row.value[CFG_W-1:0]);
			end else begin
				offer_item(row.value, row.mark_last);
				predict_reorder(row.value, row.mark_last, fresh);
				if (row.typed)
					fresh = '{'{row.exp_value, row.exp_last}};
				foreach (fresh[i])
					reordered_q.push_back(fresh[i]);
			end
		end

		// Random stages, one group size each. A stage may end in the middle of a
		// sequence, so the next size also takes effect on values already held.
		stage = 0;
		while (items_sent < RANDOM_ITEMS) begin
			sz = (stage < 12) ? phase_sizes[stage] : CFG_W'($urandom_range(0, 31));
			write_group_size(sz);
			steady_send = ($urandom_range(0, 3) == 0);
			stage_items = $urandom_range(12, 30);
			if (stage == 0) begin
				// Back-to-back requests against a stalled receiver fill the row.
				steady_send  = 1'b1;
				hold_request = 1'b1;
				stage_items  = 40;
			end
			for (int j = 0; j < stage_items; j++) begin
				if (run_left == 0)
					run_left = $urandom_range(1, 2 * active_size(sz) + 3);
				// Now and then a sequence is cut short by an early last mark.
				mark_last = (run_left == 1) || ($urandom_range(0, 19) == 0);
				run_left  = mark_last ? 0 : run_left - 1;
				send_and_predict(pick_value(), mark_last);
			end
			if (stage == 0 || $urandom_range(0, 4) == 0) begin
				s_tvalid <= 1'b0;
				steady_send = 1'b0;
				wait_drained();
				@(posedge clk);
			end
			stage++;
		end

		s_tvalid <= 1'b0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d requests and %0d results over %0d size writes,",
			items_sent, results_seen, cfg_writes);
		$display("including saturated, pass-through and lowered-mid-group sizes.");
		if (mismatches == 0 && reordered_q.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches, reordered_q.size());
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
